>>> sv/rhse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and moduli for the substring hash engine.
// No dependencies; every other file of the block imports this package.
package rhse_pkg;

    // Longest string the prefix store can hold.
    localparam int MAX_LEN = 4096;
    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // Field widths of the channels.
    localparam int ACT_W = 2;
    localparam int LETTER_W = 5;
    localparam int POS_W = 13;
    localparam int STATUS_W = 2;
    localparam int HASH_W = 30;

    // Arithmetic width: three times the largest modulus still fits.
    localparam int ACC_W = 32;
    localparam int NUM_MOD = 3;
    localparam int LANES = 2 * NUM_MOD;
    localparam int CNT_W = $clog2(HASH_W);

    localparam logic [ACC_W-1:0] PRIMES [NUM_MOD] = '{
        32'd998244353,
        32'd1000000007,
        32'd1000000009
    };

    localparam logic [HASH_W-1:0] BASE_RESET = 30'd233;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef logic [HASH_W-1:0] hash_t;
    typedef logic [LEN_W-1:0] len_t;
    // One memory word: the three residues, modulus k at bits [k*HASH_W +: HASH_W].
    typedef logic [NUM_MOD*HASH_W-1:0] triple_t;
    typedef hash_t [LANES-1:0] lane_vec_t;

endpackage

>>> sv/rhse_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the substring hash engine: request, response, configuration.
// Depends on rhse_pkg for the field widths.
interface rhse_req_if;
    import rhse_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [LETTER_W-1:0] letter;
    logic [POS_W-1:0]    left_pos;
    logic [POS_W-1:0]    right_pos;

    modport source (output valid, action, letter, left_pos, right_pos, input ready);
    modport sink (input valid, action, letter, left_pos, right_pos, output ready);
endinterface

interface rhse_rsp_if;
    import rhse_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [HASH_W-1:0]   hash_first;
    logic [HASH_W-1:0]   hash_second;
    logic [HASH_W-1:0]   hash_third;

    modport source (output valid, status, hash_first, hash_second, hash_third, input ready);
    modport sink (input valid, status, hash_first, hash_second, hash_third, output ready);
endinterface

interface rhse_cfg_if;
    import rhse_pkg::*;

    logic              valid;
    logic              ready;
    logic [HASH_W-1:0] hash_base;

    modport source (output valid, hash_base, input ready);
    modport sink (input valid, hash_base, output ready);
endinterface

>>> sv/rolling_hash_substring_engine.sv
`timescale 1ns / 1ps
// Top level of the substring hash engine: prefix and power stores, sequencer, output register.
// Depends on rhse_pkg, the channel interfaces in rhse_if and the multiplier rhse_mulmod.
//
// The engine keeps the prefix hashes of one string under the three moduli 998244353,
// 1000000007 and 1000000009, together with the power of the base at every length. Each
// request word carries an action: append adds one letter, clear empties the string, and
// query returns the three hashes of positions left_pos..right_pos (1-based, inclusive).
// Every request gives exactly one response word; its hash fields are zero unless a query
// succeeds, and its status reports a bad query range or an append to a full store. Words
// are taken one at a time. Append and query run the 30-step bit-serial modular multiplier,
// which processes all three moduli side by side (one base bit or power bit per cycle);
// clear, out-of-range queries, full-store appends and the unused action code bypass it.
// A finished response waits in the output register while the next request is accepted
// and processed. The stores need no clearing pass after reset: their zero entry is
// supplied by logic, and every other entry is written before it can be read. The base
// register may be written only while the engine is idle.
module rolling_hash_substring_engine (
    input logic         clk,
    input logic         rst_n,
    rhse_cfg_if.sink    cfg,
    rhse_req_if.sink    req,
    rhse_rsp_if.source  rsp
);
    import rhse_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_APP_MUL  = 3'd1;
    localparam logic [2:0] S_APP_WAIT = 3'd2;
    localparam logic [2:0] S_Q_MUL    = 3'd3;
    localparam logic [2:0] S_Q_WAIT   = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    localparam int CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

    // Control state.
    logic [2:0]    state_reg, state_next;
    len_t          len_reg, len_next;
    hash_t         base_reg;
    logic          out_valid_reg, out_valid_next;

    // Item and result payload.
    logic [LETTER_W-1:0] letter_reg;
    logic [POS_W-1:0]    right_reg;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    triple_t             pend_hash_reg, pend_hash_next;
    logic [STATUS_W-1:0] out_status_reg;
    triple_t             out_hash_reg;
    logic                load_out;

    // Prefix and power stores, one word holds all three residues.
    triple_t prefix_mem [0:MAX_LEN];
    triple_t power_mem [0:MAX_LEN];
    triple_t pre_rd_reg, pow_rd_reg;
    logic    pre_zero_reg, pow_zero_reg;
    triple_t pre_word, pow_word;
    logic    pre_re, pow_re, mem_we;
    len_t    pre_addr, pow_addr, wr_addr;
    triple_t new_prefix, new_power, q_hash;

    // Multiplier.
    logic      mm_start, mm_done;
    lane_vec_t mm_a, mm_b, mm_product;

    // Request decode.
    logic             req_fire;
    logic             q_bad;
    logic             store_full;
    logic [POS_W-1:0] span;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire = req.valid && (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign q_bad = (req.left_pos == '0)
                   || (CMP_W'(req.left_pos) > CMP_W'(req.right_pos))
                   || (CMP_W'(req.right_pos) > CMP_W'(len_reg));
    assign store_full = (len_reg == LEN_W'(MAX_LEN));
    assign span = req.right_pos - req.left_pos + POS_W'(1);

    // Entry zero is never written; its fixed contents are muxed in here.
    assign pre_word = pre_zero_reg ? '0 : pre_rd_reg;
    assign pow_word = pow_zero_reg ? {NUM_MOD{hash_t'(1)}} : pow_rd_reg;

    // Read address selection. A query reads prefix[l-1] and power[r-l+1] on acceptance
    // and prefix[r] in the cycle after, while the multiplier takes its operands.
    always_comb
    begin
        pre_re = 1'b0;
        pow_re = 1'b0;
        pre_addr = len_reg;
        pow_addr = len_reg;
        if (req_fire)
        begin
            pre_re = 1'b1;
            pow_re = 1'b1;
            if (req.action == ACT_QUERY)
            begin
                pre_addr = LEN_W'(req.left_pos - POS_W'(1));
                pow_addr = LEN_W'(span);
            end
        end
        else if (state_reg == S_Q_MUL)
        begin
            pre_re = 1'b1;
            pre_addr = LEN_W'(right_reg);
        end
    end

    assign wr_addr = len_reg + LEN_W'(1);

    // Final corrections after the multiplier: add the letter for an append, and take
    // the difference for a query, both folded back into 0..p-1.
    always_comb
    begin : fixup
        logic [ACC_W-1:0] p;
        logic [ACC_W-1:0] sum;
        logic [ACC_W-1:0] hr;
        logic [ACC_W-1:0] tq;
        for (int k = 0; k < NUM_MOD; k++)
        begin
            p = PRIMES[k];
            sum = ACC_W'(mm_product[k]) + ACC_W'(letter_reg);
            new_prefix[k*HASH_W +: HASH_W] = (sum >= p) ? HASH_W'(sum - p) : HASH_W'(sum);
            new_power[k*HASH_W +: HASH_W] = mm_product[NUM_MOD + k];
            hr = ACC_W'(pre_word[k*HASH_W +: HASH_W]);
            tq = ACC_W'(mm_product[k]);
            q_hash[k*HASH_W +: HASH_W] = (hr >= tq) ? HASH_W'(hr - tq) : HASH_W'(hr + p - tq);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        len_next = len_reg;
        pend_status_next = pend_status_reg;
        pend_hash_next = pend_hash_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        load_out = 1'b0;
        mm_start = 1'b0;
        mem_we = 1'b0;
        mm_a = '0;
        mm_b = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    pend_status_next = ST_OK;
                    pend_hash_next = '0;
                    unique case (req.action)
                        ACT_APPEND:
                        begin
                            if (store_full)
                            begin
                                pend_status_next = ST_FULL;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_APP_MUL;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            len_next = '0;
                            state_next = S_FINISH;
                        end
                        ACT_QUERY:
                        begin
                            if (q_bad)
                            begin
                                pend_status_next = ST_RANGE;
                                state_next = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_Q_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_APP_MUL:
            begin
                // Lanes 0..2 advance the prefix, lanes 3..5 the power, all by the base.
                mm_start = 1'b1;
                for (int k = 0; k < NUM_MOD; k++)
                begin
                    mm_a[k] = pre_word[k*HASH_W +: HASH_W];
                    mm_b[k] = base_reg;
                    mm_a[NUM_MOD + k] = pow_word[k*HASH_W +: HASH_W];
                    mm_b[NUM_MOD + k] = base_reg;
                end
                state_next = S_APP_WAIT;
            end
            S_APP_WAIT:
            begin
                if (mm_done)
                begin
                    mem_we = 1'b1;
                    len_next = len_reg + LEN_W'(1);
                    state_next = S_FINISH;
                end
            end
            S_Q_MUL:
            begin
                // prefix[l-1] * power[r-l+1] in lanes 0..2.
                mm_start = 1'b1;
                for (int k = 0; k < NUM_MOD; k++)
                begin
                    mm_a[k] = pre_word[k*HASH_W +: HASH_W];
                    mm_b[k] = pow_word[k*HASH_W +: HASH_W];
                end
                state_next = S_Q_WAIT;
            end
            S_Q_WAIT:
            begin
                // The prefix read register now holds prefix[r].
                if (mm_done)
                begin
                    pend_hash_next = q_hash;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    rhse_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_a),
        .op_b    (mm_b),
        .done    (mm_done),
        .product (mm_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg <= '0;
            base_reg <= BASE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg <= len_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                base_reg <= cfg.hash_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            letter_reg <= req.letter;
            right_reg <= req.right_pos;
        end
        pend_status_reg <= pend_status_next;
        pend_hash_reg <= pend_hash_next;
        if (load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_hash_reg <= pend_hash_reg;
        end
    end

    // Stores: one write port, one read port each, registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            prefix_mem[wr_addr] <= new_prefix;
            power_mem[wr_addr] <= new_power;
        end
        if (pre_re)
        begin
            pre_rd_reg <= prefix_mem[pre_addr];
            pre_zero_reg <= (pre_addr == '0);
        end
        if (pow_re)
        begin
            pow_rd_reg <= power_mem[pow_addr];
            pow_zero_reg <= (pow_addr == '0);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.hash_first = out_hash_reg[0*HASH_W +: HASH_W];
    assign rsp.hash_second = out_hash_reg[1*HASH_W +: HASH_W];
    assign rsp.hash_third = out_hash_reg[2*HASH_W +: HASH_W];

endmodule

>>> sv/rhse_mulmod.sv
`timescale 1ns / 1ps
// Six-lane bit-serial modular multiplier, one multiplier bit per cycle.
// Depends on rhse_pkg; lane i reduces modulo PRIMES[i % NUM_MOD].
module rhse_mulmod (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rhse_pkg::lane_vec_t op_a,
    input  rhse_pkg::lane_vec_t op_b,
    output logic                done,
    output rhse_pkg::lane_vec_t product
);
    import rhse_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    lane_vec_t        a_reg;
    lane_vec_t        b_reg, b_next;
    lane_vec_t        acc_reg, acc_next;
    logic             last_step;

    assign last_step = (cnt_reg == CNT_W'(HASH_W - 1));

    // Horner step, MSB first: acc = 2*acc + bit*a, then fold back below p.
    // With acc and a below p the sum stays below 3p.
    always_comb
    begin : lane_step
        logic [ACC_W-1:0] p;
        logic [ACC_W-1:0] p2;
        logic [ACC_W-1:0] t;
        for (int i = 0; i < LANES; i++)
        begin
            p = PRIMES[i % NUM_MOD];
            p2 = {p[ACC_W-2:0], 1'b0};
            t = ACC_W'({acc_reg[i], 1'b0})
                + (b_reg[i][HASH_W-1] ? ACC_W'(a_reg[i]) : '0);
            if (t >= p2)
            begin
                acc_next[i] = HASH_W'(t - p2);
            end
            else if (t >= p)
            begin
                acc_next[i] = HASH_W'(t - p);
            end
            else
            begin
                acc_next[i] = HASH_W'(t);
            end
            b_next[i] = {b_reg[i][HASH_W-2:0], 1'b0};
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= op_a;
            b_reg <= op_b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            b_reg <= b_next;
            acc_reg <= acc_next;
        end
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

>>> sv/rhse_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the substring hash engine and its bind to the top level.
// Depends on rhse_pkg for the moduli and status codes.
module rhse_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [rhse_pkg::STATUS_W-1:0] rsp_status,
    input logic [rhse_pkg::HASH_W-1:0]   rsp_hash_first,
    input logic [rhse_pkg::HASH_W-1:0]   rsp_hash_second,
    input logic [rhse_pkg::HASH_W-1:0]   rsp_hash_third
);
    import rhse_pkg::*;

    // Requests accepted whose response has not yet been taken.
    logic [1:0] open_reg, open_next;

    always_comb
    begin
        open_next = open_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            open_next = open_reg + 2'd1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            open_next = open_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= '0;
        end
        else
        begin
            open_reg <= open_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_hash_first) && $stable(rsp_hash_second)
            && $stable(rsp_hash_third))
        else $error("response word changed while stalled");

    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != ST_OK |-> rsp_hash_first == '0
            && rsp_hash_second == '0 && rsp_hash_third == '0)
        else $error("nonzero hash with an error status");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ACC_W'(rsp_hash_first) < PRIMES[0]
            && ACC_W'(rsp_hash_second) < PRIMES[1]
            && ACC_W'(rsp_hash_third) < PRIMES[2])
        else $error("hash not reduced below its modulus");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> open_reg != 2'd0)
        else $error("response word without an accepted request");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> open_reg != 2'd2)
        else $error("request accepted with two responses outstanding");

endmodule

bind rolling_hash_substring_engine rhse_checker u_rhse_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_hash_first  (rsp.hash_first),
    .rsp_hash_second (rsp.hash_second),
    .rsp_hash_third  (rsp.hash_third)
);

>>> tb/sv/substring_hash_checker.sv
`timescale 1ns / 1ps
// Response checker for the substring hash engine: tracks the string's prefix hashes and
// compares every response word with the predicted one. Depends on rhse_pkg and rhse_if.
module substring_hash_checker
    import rhse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    rhse_cfg_if        cfg_mon,
    rhse_req_if        req_mon,
    rhse_rsp_if        rsp_mon,
    output int         errors,
    output int         pending
);

    localparam longint unsigned MODULI [NUM_MOD] = '{
        64'd998244353,
        64'd1000000007,
        64'd1000000009
    };
    localparam logic [HASH_W-1:0] BASE_AFTER_RESET = 30'd233;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        hash_t               first;
        hash_t               second;
        hash_t               third;
    } hash_word_t;

    hash_t        prefix_mem [NUM_MOD][MAX_LEN+1];
    hash_t        power_mem [NUM_MOD][MAX_LEN+1];
    int unsigned  string_len;
    hash_t        base_reg;
    hash_word_t   expected_words [$];
    int unsigned  word_count;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t word %0d: %s", $time, word_count, msg);
        errors++;
    endtask

    // Applies one request word to the tracked string and returns the response it must give.
    function automatic hash_word_t compute_hash_word(
        input logic [ACT_W-1:0]    act,
        input logic [LETTER_W-1:0] ltr,
        input logic [POS_W-1:0]    lp,
        input logic [POS_W-1:0]    rp
    );
        hash_word_t      w;
        hash_t           sub [NUM_MOD];
        longint unsigned p;
        longint unsigned a;
        longint unsigned b;
        longint unsigned t;
        w = '0;
        for (int k = 0; k < NUM_MOD; k++)
        begin
            sub[k] = '0;
        end
        if (act == ACT_APPEND)
        begin
            if (string_len >= MAX_LEN)
            begin
                w.status = ST_FULL;
            end
            else
            begin
                for (int k = 0; k < NUM_MOD; k++)
                begin
                    p = MODULI[k];
                    a = prefix_mem[k][string_len];
                    b = power_mem[k][string_len];
                    a = (a * base_reg + ltr) % p;
                    b = (b * base_reg) % p;
                    prefix_mem[k][string_len + 1] = a[HASH_W-1:0];
                    power_mem[k][string_len + 1] = b[HASH_W-1:0];
                end
                string_len++;
            end
        end
        else if (act == ACT_CLEAR)
        begin
            // Stored powers stay; they are rewritten before a query can reach them.
            string_len = 0;
        end
        else if (act == ACT_QUERY)
        begin
            if (lp == 0 || lp > rp || rp > string_len)
            begin
                w.status = ST_RANGE;
            end
            else
            begin
                for (int k = 0; k < NUM_MOD; k++)
                begin
                    p = MODULI[k];
                    a = prefix_mem[k][lp - 1];
                    b = power_mem[k][rp - lp + 1];
                    t = (a * b) % p;
                    a = prefix_mem[k][rp];
                    a = (a % p + p - t) % p;
                    sub[k] = a[HASH_W-1:0];
                end
            end
        end
        w.first = sub[0];
        w.second = sub[1];
        w.third = sub[2];
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        hash_word_t want;
        if (!rst_n)
        begin
            string_len = 0;
            base_reg = BASE_AFTER_RESET;
            for (int k = 0; k < NUM_MOD; k++)
            begin
                prefix_mem[k][0] = '0;
                power_mem[k][0] = 30'd1;
            end
            expected_words.delete();
            word_count = 0;
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_mon.valid === 1'b1 && cfg_mon.ready === 1'b1)
            begin
                base_reg = cfg_mon.hash_base;
            end
            if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            begin
                want = compute_hash_word(req_mon.action, req_mon.letter,
                                         req_mon.left_pos, req_mon.right_pos);
                expected_words.insert(expected_words.size(), want);
            end
            if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1)
            begin
                if (expected_words.size() == 0)
                begin
                    report_mismatch($sformatf("response with no request waiting, status %0d",
                                              rsp_mon.status));
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp_mon.status !== want.status)
                    begin
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  rsp_mon.status, want.status));
                    end
                    if (rsp_mon.hash_first !== want.first)
                    begin
                        report_mismatch($sformatf("hash_first got %0d expected %0d",
                                                  rsp_mon.hash_first, want.first));
                    end
                    if (rsp_mon.hash_second !== want.second)
                    begin
                        report_mismatch($sformatf("hash_second got %0d expected %0d",
                                                  rsp_mon.hash_second, want.second));
                    end
                    if (rsp_mon.hash_third !== want.third)
                    begin
                        report_mismatch($sformatf("hash_third got %0d expected %0d",
                                                  rsp_mon.hash_third, want.third));
                    end
                end
                word_count++;
            end
            pending <= expected_words.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the substring hash engine: clock, reset, request and base stimulus,
// response back-pressure and the verdict. Depends on rhse_pkg, rhse_if,
// rolling_hash_substring_engine and substring_hash_checker.
module tb_top;
    import rhse_pkg::*;

    // Action code that the engine must ignore apart from answering with status ok.
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    // The slowest correct run is roughly 5200 words.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 400;
    // Longer than an append or query takes.
    localparam int DRAIN_CYCLES = 40;
    localparam logic [HASH_W-1:0] BASE_TOP = 30'd998244352;
    localparam logic [HASH_W-1:0] BASE_ALL_ONES = 30'h3FFFFFFF;
    localparam logic [POS_W-1:0] POS_ALL_ONES = 13'h1FFF;

    logic clk;
    logic rst_n;

    rhse_cfg_if cfg_ch ();
    rhse_req_if req_ch ();
    rhse_rsp_if rsp_ch ();

    int errors;
    int pending;
    int cycle_count = 0;
    // Length of the string as the stimulus sees it, used to aim queries at valid ranges.
    int str_len = 0;
    bit idle_on = 1'b1;
    bit long_hold_req = 1'b0;

    rolling_hash_substring_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    substring_hash_checker hash_monitor (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_mon (cfg_ch),
        .req_mon (req_ch),
        .rsp_mon (rsp_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Guard against a hang: a stuck handshake never lets the stimulus finish.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Response side. Ready changes on the falling edge. Normally it drops in short random
    // bursts; on request it stays low for a long stretch so that the output register and
    // then the request input back up.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
            begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    // Offers one request word and returns once it is accepted. Valid is left high so that
    // back-to-back words need no gap; a random idle burst may come first.
    task automatic push_word(
        input logic [ACT_W-1:0]    act,
        input logic [LETTER_W-1:0] ltr,
        input logic [POS_W-1:0]    lp,
        input logic [POS_W-1:0]    rp
    );
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.action = act;
        req_ch.letter = ltr;
        req_ch.left_pos = lp;
        req_ch.right_pos = rp;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
    endtask

    // Unused fields of a word carry random values so that every bit moves.
    task automatic push_append(input logic [LETTER_W-1:0] ltr);
        push_word(ACT_APPEND, ltr, POS_W'($urandom), POS_W'($urandom));
        if (str_len < MAX_LEN)
        begin
            str_len++;
        end
    endtask

    task automatic push_query(input logic [POS_W-1:0] lp, input logic [POS_W-1:0] rp);
        push_word(ACT_QUERY, LETTER_W'($urandom), lp, rp);
    endtask

    task automatic push_clear();
        push_word(ACT_CLEAR, LETTER_W'($urandom), POS_W'($urandom), POS_W'($urandom));
        str_len = 0;
    endtask

    // Mostly real letters, now and then the codes above 'z' that the engine takes as given.
    function automatic logic [LETTER_W-1:0] pick_letter();
        return ($urandom_range(0, 6) == 0) ? LETTER_W'($urandom_range(26, 31))
                                           : LETTER_W'($urandom_range(0, 25));
    endfunction

    // Drops valid and waits until every response word has come back.
    task automatic settle();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic change_base(input logic [HASH_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.hash_base = value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Random traffic: mostly appends and queries on valid ranges, with a share of broken
    // queries, clears and words carrying the unused action code.
    task automatic run_random(input int count);
        int unsigned roll;
        int unsigned lo;
        int unsigned hi;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                push_append(pick_letter());
            end
            else if (roll < 80)
            begin
                if (str_len > 0)
                begin
                    lo = $urandom_range(1, str_len);
                    hi = $urandom_range(lo, str_len);
                end
                else
                begin
                    lo = 1;
                    hi = $urandom_range(1, 5);
                end
                push_query(POS_W'(lo), POS_W'(hi));
            end
            else if (roll < 88)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = 0;
                        hi = $urandom_range(0, 8191);
                    end
                    1:
                    begin
                        hi = $urandom_range(0, 100);
                        lo = hi + 1 + $urandom_range(0, 50);
                    end
                    2:
                    begin
                        hi = str_len + 1 + $urandom_range(0, 20);
                        lo = $urandom_range(1, hi);
                    end
                    default:
                    begin
                        lo = $urandom_range(0, 8191);
                        hi = $urandom_range(0, 8191);
                    end
                endcase
                push_query(POS_W'(lo), POS_W'(hi));
            end
            else if (roll < 94)
            begin
                push_clear();
            end
            else
            begin
                push_word(ACT_UNUSED, LETTER_W'($urandom), POS_W'($urandom), POS_W'($urandom));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.hash_base = '0;
        req_ch.valid = 1'b0;
        req_ch.action = ACT_APPEND;
        req_ch.letter = '0;
        req_ch.left_pos = '0;
        req_ch.right_pos = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed words under the reset base: queries on an empty string, letters at both
        // ends of the field, every kind of bad range, the unused action code and clear.
        push_query(13'd1, 13'd1);
        push_query(13'd0, 13'd0);
        push_append(5'd0);
        push_append(5'd25);
        push_append(5'd31);
        push_append(5'd7);
        push_query(13'd1, 13'd4);
        push_query(13'd2, 13'd3);
        push_query(13'd4, 13'd4);
        push_query(13'd1, 13'd1);
        push_query(13'd0, 13'd2);
        push_query(13'd3, 13'd2);
        push_query(13'd1, 13'd5);
        push_query(POS_ALL_ONES, POS_ALL_ONES);
        push_word(ACT_UNUSED, 5'd31, POS_ALL_ONES, POS_ALL_ONES);
        push_word(ACT_UNUSED, 5'd0, 13'd0, 13'd0);
        push_query(13'd1, 13'd4);
        push_clear();
        push_query(13'd1, 13'd1);
        push_append(5'd12);
        push_query(13'd1, 13'd1);
        push_clear();

        // Random phases under several bases. No clear comes with a base change, so a string
        // often carries letters hashed under two bases.
        change_base(30'd1);
        run_random(60);
        change_base(BASE_TOP);
        run_random(100);
        change_base(30'd0);
        run_random(60);
        change_base(BASE_ALL_ONES);
        run_random(100);

        // Long response hold-off while requests keep coming, so the engine stalls its input.
        change_base(HASH_W'($urandom));
        long_hold_req = 1'b1;
        run_random(130);

        // Fill the store to the top, then append to a full store and query its far end.
        change_base(HASH_W'($urandom_range(1, 998244352)));
        while (str_len < MAX_LEN)
        begin
            push_append(pick_letter());
        end
        push_append(pick_letter());
        push_append(5'd31);
        push_query(13'd1, POS_W'(MAX_LEN));
        push_query(POS_W'(MAX_LEN), POS_W'(MAX_LEN));
        push_query(13'd1, POS_W'(MAX_LEN + 1));
        push_query(POS_W'(MAX_LEN + 1), POS_W'(MAX_LEN + 1));
        push_query(13'd2048, 13'd4000);
        for (int i = 0; i < 20; i++)
        begin
            push_query(POS_W'($urandom_range(1, 2048)), POS_W'($urandom_range(2048, MAX_LEN)));
        end

        // After a clear, new appends overwrite the powers left over from the full string.
        change_base(HASH_W'($urandom));
        run_random(300);

        // The closing stretch runs with no idling on either side.
        change_base(HASH_W'($urandom_range(1, 998244352)));
        idle_on = 1'b0;
        run_random(150);

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
